// ===== rtl/core/fnvsm_pkg.sv =====
// Shared constants and types for the FNV-1a / splitmix64 digest block.
`default_nettype none
package fnvsm_pkg;

   localparam logic [63:0] FNV_BASIS  = 64'hcbf29ce484222325;
   localparam logic [8:0]  FNV_PRIME_LOW = 9'h1b3;
   localparam int          FNV_PRIME_SHIFT = 40;
   localparam logic [63:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL_B  = 64'h94d049bb133111eb;

   localparam int SEED_DEPTH = 2;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_PREP = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_FIN  = 4'b1000
   } back_state_type;

   typedef enum logic [1:0] {
      PART_LO  = 2'd0,
      PART_MID = 2'd1,
      PART_HI  = 2'd2
   } mul_part_type;

endpackage
`default_nettype wire

// ===== rtl/core/fnv1a64_splitmix_digest_top.sv =====
// Top level of the FNV-1a 64-bit hash with splitmix64 digest expansion.
// Message bytes are taken one per cycle; the FNV prime multiply is a 40-bit shift plus a
// 9-bit constant multiply, so folding never stalls while the seed queue has room. On the
// last byte the final state enters a two-entry seed queue and the hash restarts from the
// offset basis. The back end turns a seed into DIGEST_WORDS words with a single 32x32
// multiplier used three times per 64-bit product; a finished word waits until the output
// register is free, and the next seed is popped only after the last word is loaded.
// req_full rises only when two seeds are already waiting in the queue.
`default_nettype none
module fnv1a64_splitmix_digest_top #(
   parameter int DIGEST_WORDS = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [63:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);
   import fnvsm_pkg::*;

   queue_stat_type q_stat;
   logic           q_push;
   logic [63:0]    q_push_data;
   logic           q_pop;
   logic [63:0]    q_pop_data;

   fnvsm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .req_full      (req_full),
      .q_stat        (q_stat),
      .q_push        (q_push),
      .q_data        (q_push_data)
   );

   fnvsm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .stat      (q_stat)
   );

   fnvsm_back #(
      .DIGEST_WORDS (DIGEST_WORDS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_stat          (q_stat),
      .q_data          (q_pop_data),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );
endmodule
`default_nettype wire

// ===== rtl/core/fnvsm_front.sv =====
// Front end: folds one byte per cycle into the FNV-1a state while the seed queue has room; pushes finished seeds.
`default_nettype none
module fnvsm_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_push,
   input  wire logic [7:0]              req_data_byte,
   input  wire logic                    req_last_byte,
   output logic                         req_full,
   input  wire fnvsm_pkg::queue_stat_type q_stat,
   output logic                         q_push,
   output logic [63:0]                  q_data
);
   import fnvsm_pkg::*;

   logic [63:0] hash_ff;
   logic [63:0] hash_in;
   logic [63:0] folded;
   logic [63:0] low_prod;
   logic [63:0] next_hash;
   logic        transfer;

   assign req_full  = q_stat.full;
   assign transfer  = req_push && !req_full;
   assign folded    = hash_ff ^ {56'd0, req_data_byte};
   assign low_prod  = folded * {55'd0, FNV_PRIME_LOW};
   assign next_hash = (folded << FNV_PRIME_SHIFT) + low_prod;
   assign q_push    = transfer && req_last_byte;
   assign q_data    = next_hash;

   always_comb begin
      hash_in = hash_ff;
      if (transfer) begin
         hash_in = req_last_byte ? FNV_BASIS : next_hash;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= FNV_BASIS;
      end else begin
         hash_ff <= hash_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/fnvsm_queue.sv =====
// Two-entry seed queue between the front and back ends.
`default_nettype none
module fnvsm_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire logic [63:0]         push_data,
   input  wire logic                pop,
   output logic [63:0]              pop_data,
   output fnvsm_pkg::queue_stat_type stat
);
   import fnvsm_pkg::*;

   logic [63:0] mem_ff [SEED_DEPTH];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign stat.full  = (count_ff == 2'(SEED_DEPTH));
   assign stat.empty = (count_ff == 2'd0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/fnvsm_back.sv =====
// Back end: expands a seed into digest words with one shared 32x32 multiplier.
`default_nettype none
module fnvsm_back #(
   parameter int DIGEST_WORDS = 4
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire fnvsm_pkg::queue_stat_type q_stat,
   input  wire logic [63:0]             q_data,
   output logic                         q_pop,
   output logic                         rsp_empty,
   input  wire logic                    rsp_pop,
   output logic [63:0]                  rsp_digest_word,
   output logic [2:0]                   rsp_word_index,
   output logic                         rsp_last_word
);
   import fnvsm_pkg::*;

   localparam logic [2:0] LAST_INDEX = 3'(DIGEST_WORDS - 1);

   back_state_type state_ff, state_in;
   mul_part_type   part_ff, part_in;
   logic           pass_ff, pass_in;
   logic [2:0]     word_ff, word_in;
   logic [63:0]    x_ff, x_in;
   logic [63:0]    v_ff, v_in;
   logic [63:0]    acc_ff, acc_in;
   logic           out_valid_ff, out_valid_in;
   logic [63:0]    out_word_ff;
   logic [2:0]     out_index_ff;
   logic           out_last_ff;

   logic [63:0] mul_const;
   logic [31:0] op_a, op_b;
   logic [63:0] prod;
   logic        can_load;
   logic        load;

   assign mul_const = pass_ff ? MIX_MUL_B : MIX_MUL_A;
   assign prod      = {32'd0, op_a} * {32'd0, op_b};
   assign can_load  = !out_valid_ff || rsp_pop;

   always_comb begin
      op_a = v_ff[31:0];
      op_b = mul_const[31:0];
      unique case (part_ff)
         PART_LO: begin
            op_a = v_ff[31:0];
            op_b = mul_const[31:0];
         end
         PART_MID: begin
            op_a = v_ff[31:0];
            op_b = mul_const[63:32];
         end
         PART_HI: begin
            op_a = v_ff[63:32];
            op_b = mul_const[31:0];
         end
         default: begin
            op_a = v_ff[31:0];
            op_b = mul_const[31:0];
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      part_in  = part_ff;
      pass_in  = pass_ff;
      word_in  = word_ff;
      x_in     = x_ff;
      v_in     = v_ff;
      acc_in   = acc_ff;
      q_pop    = 1'b0;
      load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               q_pop    = 1'b1;
               x_in     = q_data + GOLDEN_INC;
               word_in  = 3'd0;
               pass_in  = 1'b0;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            v_in     = pass_ff ? (acc_ff ^ (acc_ff >> 27)) : (x_ff ^ (x_ff >> 30));
            part_in  = PART_LO;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            unique case (part_ff)
               PART_LO: begin
                  acc_in  = prod;
                  part_in = PART_MID;
               end
               PART_MID: begin
                  acc_in  = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};
                  part_in = PART_HI;
               end
               PART_HI: begin
                  acc_in = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};
                  if (pass_ff) begin
                     state_in = ST_FIN;
                  end else begin
                     pass_in  = 1'b1;
                     state_in = ST_PREP;
                  end
               end
               default: begin
                  part_in = PART_LO;
               end
            endcase
         end
         ST_FIN: begin
            if (can_load) begin
               load = 1'b1;
               if (word_ff == LAST_INDEX) begin
                  state_in = ST_IDLE;
               end else begin
                  x_in     = x_ff + GOLDEN_INC;
                  word_in  = word_ff + 3'd1;
                  pass_in  = 1'b0;
                  state_in = ST_PREP;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      out_valid_in = (out_valid_ff && !rsp_pop) || load;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_word_ff  <= acc_ff ^ (acc_ff >> 31);
         out_index_ff <= word_ff;
         out_last_ff  <= (word_ff == LAST_INDEX);
      end
   end

   always_ff @(posedge clock) begin
      part_ff <= part_in;
      pass_ff <= pass_in;
      word_ff <= word_in;
      x_ff    <= x_in;
      v_ff    <= v_in;
      acc_ff  <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_digest_word = out_word_ff;
   assign rsp_word_index  = out_index_ff;
   assign rsp_last_word   = out_last_ff;
endmodule
`default_nettype wire

// ===== rtl/core/fnvsm_checker.sv =====
// Port-level checks for the digest block, bound to the top level.
`default_nettype none
module fnvsm_checker #(
   parameter int DIGEST_WORDS = 4
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_push,
   input wire logic        req_full,
   input wire logic [7:0]  req_data_byte,
   input wire logic        req_last_byte,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [63:0] rsp_digest_word,
   input wire logic [2:0]  rsp_word_index,
   input wire logic        rsp_last_word
);
   localparam logic [2:0] LAST_INDEX = 3'(DIGEST_WORDS - 1);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("block not empty after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_digest_word)
         && $stable(rsp_word_index) && $stable(rsp_last_word))
      else $error("waiting result changed");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_last_word == (rsp_word_index == LAST_INDEX)))
      else $error("last word flag disagrees with index");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_word_index <= LAST_INDEX)
      else $error("word index out of range");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_pop && !rsp_last_word ##1 !rsp_empty
         |-> rsp_word_index == $past(rsp_word_index) + 3'd1)
      else $error("word index did not advance");

   logic unused_inputs;
   assign unused_inputs = req_push ^ (^req_data_byte) ^ req_last_byte;
endmodule

bind fnv1a64_splitmix_digest_top fnvsm_checker #(.DIGEST_WORDS(DIGEST_WORDS)) u_checker (.*);
`default_nettype wire

// ===== sim/fnv1a64_splitmix_digest_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the FNV-1a 64-bit hash block with splitmix64 digest words.
module fnv1a64_splitmix_digest_top_tb;
   import fnvsm_pkg::*;

   localparam int          DIGEST_WORDS  = 4;
   localparam logic [63:0] PRIME64       = 64'h100000001b3;
   localparam int          DIGEST_CYCLES = 1 + 9 * DIGEST_WORDS;
   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          RANDOM_ITEMS  = 130;

   typedef struct packed {
      logic [63:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_push      = 1'b0;
   logic        req_full;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop       = 1'b0;
   logic [63:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   digest_word_type words_due[$];
   logic [63:0]  running_hash = FNV_BASIS;
   int           mismatches   = 0;
   int           cycle_count  = 0;
   int           pop_stall    = 0;
   bit           quiet        = 1'b0;
   bit           hold_pop     = 1'b0;

   fnv1a64_splitmix_digest_top #(
      .DIGEST_WORDS(DIGEST_WORDS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_digest_word(rsp_digest_word),
      .rsp_word_index (rsp_word_index),
      .rsp_last_word  (rsp_last_word)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [63:0] splitmix(input logic [63:0] v);
      logic [63:0] m;
      m = (v ^ (v >> 30)) * MIX_MUL_A;
      m = (m ^ (m >> 27)) * MIX_MUL_B;
      return m ^ (m >> 31);
   endfunction

   task automatic fold_digest_byte(input logic [7:0] b, input logic last);
      logic [63:0]     ctr;
      digest_word_type w;
      int              k;
      running_hash = (running_hash ^ {56'd0, b}) * PRIME64;
      if (last) begin
         ctr = running_hash;
         for (k = 0; k < DIGEST_WORDS; k++) begin
            ctr     = ctr + GOLDEN_INC;
            w.word  = splitmix(ctr);
            w.index = k[2:0];
            w.last  = (k == DIGEST_WORDS - 1);
            words_due.insert(words_due.size(), w);
         end
         running_hash = FNV_BASIS;
      end
   endtask

   function automatic int pick_gap();
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 98)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      req_push      <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      fold_digest_byte(b, last);
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random_message(input int len);
      int i;
      for (i = 0; i < len; i++)
         send_byte(8'($urandom_range(0, 255)), i == len - 1);
   endtask

   task automatic check_digest_word();
      digest_word_type w;
      if (words_due.size() == 0) begin
         $error("unexpected digest word %h index %0d", rsp_digest_word, rsp_word_index);
         mismatches++;
      end else begin
         w = words_due.pop_front();
         if (rsp_digest_word !== w.word) begin
            $error("digest_word expected %h actual %h", w.word, rsp_digest_word);
            mismatches++;
         end
         if (rsp_word_index !== w.index) begin
            $error("word_index expected %0d actual %0d", w.index, rsp_word_index);
            mismatches++;
         end
         if (rsp_last_word !== w.last) begin
            $error("last_word expected %0d actual %0d", w.last, rsp_last_word);
            mismatches++;
         end
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            check_digest_word();
            pop_stall = pick_gap();
         end
         if (reset || hold_pop) begin
            rsp_pop <= 1'b0;
         end else if (pop_stall > 0) begin
            rsp_pop <= 1'b0;
            pop_stall--;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   task automatic wait_for_digests();
      req_push <= 1'b0;
      while (words_due.size() != 0)
         @(posedge clock);
      repeat (2 * DIGEST_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed_messages();
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b1);
      send_byte(8'h55, 1'b0);
      send_byte(8'haa, 1'b1);
      send_byte(8'h01, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7f, 1'b0);
      send_byte(8'hfe, 1'b1);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h63, 1'b1);
      repeat (5) send_byte(8'hff, 1'b0);
      send_byte(8'h00, 1'b1);
      repeat (3) send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b1);
   endtask

   task automatic test_queue_full();
      hold_pop = 1'b1;
      quiet    = 1'b1;
      fork
         begin
            repeat (4) send_byte(8'($urandom_range(0, 255)), 1'b1);
         end
         begin
            wait (req_full === 1'b1);
            repeat (DIGEST_CYCLES) @(posedge clock);
            hold_pop = 1'b0;
         end
      join
      quiet = 1'b0;
      wait_for_digests();
   endtask

   task automatic test_back_to_back();
      quiet = 1'b1;
      repeat (3) send_random_message($urandom_range(2, 6));
      quiet = 1'b0;
   endtask

   task automatic test_random_messages();
      int sent;
      int len;
      int r;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 70)
            len = $urandom_range(1, 4);
         else if (r < 95)
            len = $urandom_range(5, 12);
         else
            len = $urandom_range(13, 40);
         quiet = ($urandom_range(0, 7) == 0);
         send_random_message(len);
         sent += len;
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_messages();
      wait_for_digests();
      test_queue_full();
      test_back_to_back();
      test_random_messages();
      wait_for_digests();
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== fnv1a64_splitmix_digest_top.f =====
rtl/core/fnvsm_pkg.sv
rtl/core/fnvsm_front.sv
rtl/core/fnvsm_queue.sv
rtl/core/fnvsm_back.sv
rtl/core/fnv1a64_splitmix_digest_top.sv
rtl/core/fnvsm_checker.sv
sim/fnv1a64_splitmix_digest_top_tb.sv
